// ===== src/atws_pkg.sv =====
package atws_pkg;

  localparam int ATWS_CLASSES = 16;
  localparam int ATWS_ENTRIES = 32;
  localparam int CNT_W = 9;

  typedef enum logic [2:0] {
    OP_ALLOC    = 3'd0,
    OP_FREE_CLS = 3'd1,
    OP_FREE_ANY = 3'd2,
    OP_FAIL     = 3'd3,
    OP_REPORT   = 3'd4
  } opcode_t;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_NULL      = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_EVICTED   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_STAT_RD, S_STAT_WAIT, S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD,
    S_SHIFT_WR, S_APPEND, S_FREE_UPD, S_STAT_WR, S_RESULT
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [31:0] alloc_bytes;
    logic [31:0] bytes_now;
    logic [31:0] alloc_times;
    logic [31:0] times_now;
    logic [31:0] evictions;
    logic [31:0] failures;
    logic [31:0] largest;
    logic [31:0] smallest;
  } stats_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] size;
  } entry_t;

  function automatic stats_t stats_reset();
    stats_t s;
    s = '0;
    s.smallest = '1;
    return s;
  endfunction

endpackage

// ===== src/atws_ram.sv =====
module atws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/allocation_tracker_with_stats.sv =====
// Path from the accepting edge to done: a report passes S_STAT_RD and S_STAT_WAIT, a failure
// adds S_STAT_WR, an allocate adds S_APPEND and S_STAT_WR, an evicting allocate first shifts
// its list, frees scan and shift lists; each list step is a read state and a check or write state.
// Throughput: one item at a time; busy is high from the accepting edge until the state returns
// to idle after done, and the next start is taken only while idle.
// Reset: rst (synchronous) clears the control state and the per-class valid bits, so
// every class reads back as freshly reset; the receiver cannot stall, done is one cycle.
module allocation_tracker_with_stats
  import atws_pkg::*;
#(
  parameter int CLASSES = ATWS_CLASSES,
  parameter int ENTRIES = ATWS_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [3:0]  class_id,
  input  logic [31:0] address,
  input  logic [31:0] size_bytes,
  output logic        done,
  output logic [3:0]  class_out,
  output logic [2:0]  status,
  output logic [31:0] freed_bytes,
  output logic [31:0] alloc_bytes_total,
  output logic [31:0] bytes_now,
  output logic [31:0] alloc_count_total,
  output logic [31:0] count_now,
  output logic [5:0]  live_entries,
  output logic [31:0] evicted_count,
  output logic [31:0] fail_count,
  output logic [31:0] max_alloc_bytes,
  output logic [31:0] min_alloc_bytes
);
  localparam int CW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int EW = $clog2(ENTRIES);
  localparam int AW = $clog2(CLASSES * ENTRIES);
  localparam int SW = $bits(stats_t);
  localparam int EN_W = $bits(entry_t);

  state_t state, state_next;

  // latched item
  logic [2:0]       op;
  logic [3:0]       cls_in;
  logic [31:0]      addr;
  logic [31:0]      size;
  logic             cls_ok;

  // working registers
  logic [CW-1:0]    c;
  logic [CNT_W-1:0] j;
  stats_t           st;
  logic             found;
  logic             evict;
  logic             search_done;
  logic             zero_out;
  logic [31:0]      freed;
  logic [2:0]       stat_code;
  logic [3:0]       rep;
  logic [CLASSES-1:0] cls_valid;
  logic [CW-1:0]    stat_cls;

  // memory ports
  logic             ent_we;
  logic [AW-1:0]    ent_waddr, ent_raddr;
  entry_t           ent_wdata, ent_rdata;
  logic [EN_W-1:0]  ent_rbits;
  logic             sta_we;
  logic [SW-1:0]    sta_rbits;
  stats_t           stat_rd;
  stats_t           stat_in;

  logic             in_ok;
  logic             last_cls;
  logic             more_scan;
  logic             more_shift;
  logic             hit;
  logic [AW-1:0]    row_base;

  atws_ram #(.WIDTH(EN_W), .DEPTH(CLASSES * ENTRIES)) u_entries (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rbits)
  );

  atws_ram #(.WIDTH(SW), .DEPTH(CLASSES)) u_stats (
    .clk(clk), .we(sta_we), .waddr(c), .wdata(st),
    .raddr(c), .rdata(sta_rbits)
  );

  assign ent_rdata = entry_t'(ent_rbits);
  // a class never written reads as its reset value
  assign stat_rd   = cls_valid[stat_cls] ? stats_t'(sta_rbits) : stats_reset();

  // count a failure as the statistics are loaded
  always_comb begin
    stat_in = stat_rd;
    if (op == OP_FAIL) begin
      stat_in.failures = stat_rd.failures + 32'd1;
    end
  end

  assign in_ok      = int'(class_id) < CLASSES;
  assign last_cls   = int'(c) == CLASSES - 1;
  assign more_scan  = int'(j) + 1 < int'(st.cnt);
  assign more_shift = int'(j) + 2 < int'(st.cnt);
  assign hit        = ent_rdata.addr == addr;
  assign row_base   = AW'(c) * AW'(ENTRIES);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (opcode == OP_FREE_ANY) begin
            state_next = (address != '0 || in_ok) ? S_STAT_RD : S_RESULT;
          end else begin
            state_next = in_ok ? S_STAT_RD : S_RESULT;
          end
        end
      end
      S_STAT_RD: state_next = S_STAT_WAIT;
      S_STAT_WAIT: begin
        case (op)
          OP_ALLOC:    state_next = (int'(stat_rd.cnt) >= ENTRIES) ? S_SHIFT_RD : S_APPEND;
          OP_FREE_CLS: state_next = (stat_rd.cnt == '0) ? S_FREE_UPD : S_SCAN_RD;
          OP_FREE_ANY: begin
            if (search_done) begin
              state_next = S_RESULT;
            end else if (stat_rd.cnt != '0) begin
              state_next = S_SCAN_RD;
            end else if (last_cls && !cls_ok) begin
              state_next = S_RESULT;
            end else begin
              state_next = S_STAT_RD;
            end
          end
          OP_FAIL:     state_next = S_STAT_WR;
          default:     state_next = S_RESULT;
        endcase
      end
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (hit) begin
          state_next = more_scan ? S_SHIFT_RD : S_FREE_UPD;
        end else if (more_scan) begin
          state_next = S_SCAN_RD;
        end else if (op == OP_FREE_CLS) begin
          state_next = S_FREE_UPD;
        end else if (last_cls && !cls_ok) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_STAT_RD;
        end
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (more_shift) begin
          state_next = S_SHIFT_RD;
        end else begin
          state_next = evict ? S_APPEND : S_FREE_UPD;
        end
      end
      S_APPEND:   state_next = S_STAT_WR;
      S_FREE_UPD: state_next = S_STAT_WR;
      S_STAT_WR:  state_next = S_RESULT;
      S_RESULT:   state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = row_base + AW'(j[EW-1:0]);
    ent_wdata = ent_rdata;
    ent_raddr = row_base + AW'(j[EW-1:0]);
    sta_we    = 1'b0;
    case (state)
      S_SHIFT_RD: ent_raddr = row_base + AW'(j[EW-1:0]) + AW'(1);
      S_SHIFT_WR: ent_we = 1'b1;
      S_APPEND: begin
        ent_we    = 1'b1;
        ent_waddr = evict ? row_base + AW'(ENTRIES - 1) : row_base + AW'(st.cnt[EW-1:0]);
        ent_wdata = '{addr: addr, size: size};
      end
      S_STAT_WR: sta_we = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cls_valid <= '0;
    end else begin
      state <= state_next;
      if (sta_we) begin
        cls_valid[c] <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op          <= opcode;
        cls_in      <= class_id;
        addr        <= address;
        size        <= size_bytes;
        cls_ok      <= in_ok;
        rep         <= class_id;
        found       <= 1'b0;
        evict       <= 1'b0;
        freed       <= '0;
        zero_out    <= !in_ok;
        // free-any starts its search at class zero unless the address is null
        search_done <= (opcode == OP_FREE_ANY) && (address == '0);
        stat_code   <= (opcode == OP_FREE_ANY) ?
                       ((address == '0) ? ST_NULL : ST_NOT_FOUND) :
                       (in_ok ? ST_DONE : ST_INVALID);
        c           <= (opcode == OP_FREE_ANY && address != '0) ? '0 : CW'(class_id);
      end
      S_STAT_RD: stat_cls <= c;
      S_STAT_WAIT: begin
        st <= stat_in;
        j  <= '0;
        if (op == OP_ALLOC && int'(stat_rd.cnt) >= ENTRIES) begin
          evict <= 1'b1;
        end
        if (op == OP_FREE_ANY && !search_done && stat_rd.cnt == '0) begin
          // empty class: advance, or fall back to the requested class
          if (last_cls) begin
            search_done <= 1'b1;
            c           <= CW'(cls_in);
            zero_out    <= !cls_ok;
          end else begin
            c <= c + CW'(1);
          end
        end
      end
      S_SCAN_CHK: begin
        if (hit) begin
          found <= 1'b1;
          freed <= ent_rdata.size;
          if (op == OP_FREE_ANY) begin
            rep         <= 4'(c);
            stat_code   <= ST_DONE;
            zero_out    <= 1'b0;
            search_done <= 1'b1;
          end
        end else if (more_scan) begin
          j <= j + CNT_W'(1);
        end else if (op == OP_FREE_ANY) begin
          if (last_cls) begin
            search_done <= 1'b1;
            c           <= CW'(cls_in);
            zero_out    <= !cls_ok;
          end else begin
            c <= c + CW'(1);
          end
        end
      end
      S_SHIFT_WR: j <= j + CNT_W'(1);
      S_APPEND: begin
        st.cnt         <= evict ? CNT_W'(ENTRIES) : st.cnt + CNT_W'(1);
        st.alloc_bytes <= st.alloc_bytes + size;
        st.bytes_now   <= st.bytes_now + size;
        st.alloc_times <= st.alloc_times + 32'd1;
        st.times_now   <= st.times_now + 32'd1;
        if (evict) begin
          st.evictions <= st.evictions + 32'd1;
          stat_code    <= ST_EVICTED;
        end
        if (st.largest < size) begin
          st.largest <= size;
        end
        if (st.smallest > size) begin
          st.smallest <= size;
        end
      end
      S_FREE_UPD: begin
        st.bytes_now <= st.bytes_now - freed;
        st.times_now <= st.times_now - 32'd1;
        if (found) begin
          st.cnt <= st.cnt - CNT_W'(1);
        end else begin
          stat_code <= ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  // result drive: statistics are zero for an ignored class
  assign busy              = state != S_IDLE;
  assign done              = state == S_RESULT;
  assign class_out         = rep;
  assign status            = stat_code;
  assign freed_bytes       = zero_out ? '0 : freed;
  assign alloc_bytes_total = zero_out ? '0 : st.alloc_bytes;
  assign bytes_now         = zero_out ? '0 : st.bytes_now;
  assign alloc_count_total = zero_out ? '0 : st.alloc_times;
  assign count_now         = zero_out ? '0 : st.times_now;
  assign live_entries      = zero_out ? '0 : st.cnt[5:0];
  assign evicted_count     = zero_out ? '0 : st.evictions;
  assign fail_count        = zero_out ? '0 : st.failures;
  assign max_alloc_bytes   = zero_out ? '0 : st.largest;
  assign min_alloc_bytes   = zero_out ? '0 : st.smallest;

endmodule
